// ===== hw/rtl/otetb_pkg.sv =====
// Package for the overwriting event trace buffer.
// Holds the word types, command and state types, and the queue constants.
// Depends on nothing; the front, the back, the top level and the testbench import it.
package otetb_pkg;

   // Input item kinds as they arrive on the request word.
   localparam logic [1:0] KIND_RECORD    = 2'd0;
   localparam logic [1:0] KIND_READ_LAST = 2'd1;
   localparam logic [1:0] KIND_SNAPSHOT  = 2'd2;

   // Result status codes.
   localparam logic STATUS_GOOD = 1'b0;
   localparam logic STATUS_NONE = 1'b1;

   // Queue between the front and the back, and the result queue.
   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 4;
   localparam int RSP_COUNT_W     = $clog2(RSP_QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  source;
      logic [7:0]  code;
      logic [31:0] event_time;
      logic [6:0]  limit;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [7:0]  out_source;
      logic [7:0]  out_code;
      logic [31:0] out_time;
      logic [31:0] out_sequence;
      logic        last_of_run;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_RECORD,
      OP_READ_LAST,
      OP_SNAPSHOT
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  source;
      logic [7:0]  code;
      logic [31:0] event_time;
      logic [6:0]  limit;
      logic        limit_zero;
   } cmd_type;

   typedef struct packed {
      logic [7:0]  source;
      logic [7:0]  code;
      logic [31:0] time_ms;
      logic [31:0] sequence_num;
   } slot_type;

   typedef enum logic {
      ST_IDLE,
      ST_SNAP
   } state_type;

endpackage

// ===== hw/rtl/otetb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module otetb_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/otetb_fifo.sv =====
// Small flip-flop queue used for the command queue and the result queue.
// Depends on nothing.
module otetb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic [WIDTH-1:0]               push_data,
   output logic                           full,
   input  logic                           pop,
   output logic [WIDTH-1:0]               pop_data,
   output logic                           empty,
   output logic [$clog2(DEPTH + 1)-1:0]   count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/otetb_front.sv =====
// Front part: accepts request words, classifies them into commands and queues them.
// Depends on otetb_pkg and otetb_fifo.
module otetb_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  otetb_pkg::req_type req_word,
   input  logic              cmd_pop,
   output logic              cmd_empty,
   output otetb_pkg::cmd_type cmd_word
);
   import otetb_pkg::*;

   localparam int CMD_W = $bits(cmd_type);

   cmd_type           cmd_new;
   logic              cmd_valid;
   logic              accept;
   logic [CMD_W-1:0]  cmd_bits;

   assign accept = push && !full;

   // A word of an unused kind is taken and then dropped.
   always_comb begin
      cmd_valid          = 1'b1;
      cmd_new.op         = OP_RECORD;
      cmd_new.source     = req_word.source;
      cmd_new.code       = req_word.code;
      cmd_new.event_time = req_word.event_time;
      cmd_new.limit      = req_word.limit;
      cmd_new.limit_zero = (req_word.limit == '0);
      case (req_word.kind)
         KIND_RECORD:    cmd_new.op = OP_RECORD;
         KIND_READ_LAST: cmd_new.op = OP_READ_LAST;
         KIND_SNAPSHOT:  cmd_new.op = OP_SNAPSHOT;
         default:        cmd_valid  = 1'b0;
      endcase
   end

   otetb_fifo #(
      .WIDTH(CMD_W),
      .DEPTH(CMD_QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept && cmd_valid),
      .push_data(CMD_W'(cmd_new)),
      .full     (full),
      .pop      (cmd_pop),
      .pop_data (cmd_bits),
      .empty    (cmd_empty),
      .count    ()
   );

   assign cmd_word = cmd_type'(cmd_bits);

endmodule

// ===== hw/rtl/otetb_back.sv =====
// Back part: owns the ring pointers and the event RAM and carries out commands.
// Depends on otetb_pkg and otetb_ram.
module otetb_back #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_empty,
   input  otetb_pkg::cmd_type                  cmd_word,
   output logic                                cmd_pop,
   input  logic [otetb_pkg::RSP_COUNT_W-1:0]   rsp_count,
   output logic                                rsp_push,
   output otetb_pkg::rsp_type                  rsp_word
);
   import otetb_pkg::*;

   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW     = $clog2(DEPTH + 1);
   localparam int SW     = AW + 2;
   localparam int SLOT_W = $bits(slot_type);

   state_type         state_ff, state_in;
   logic [AW-1:0]     wp_ff, wp_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic [31:0]       seq_ff, seq_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]     remain_ff, remain_in;
   logic              pend_ff, pend_in;
   logic              pend_last_ff, pend_last_in;

   logic              ram_we, ram_re;
   logic [AW-1:0]     ram_raddr;
   slot_type          ram_wslot, ram_rslot;
   logic [SLOT_W-1:0] ram_rbits;

   logic [AW-1:0]     newest, first, rd_ptr_next;
   logic [SW-1:0]     first_sum;
   logic [6:0]        fill7, n7;
   logic [FW-1:0]     snap_n;
   logic [RSP_COUNT_W:0] occupancy;
   logic              room;
   logic              direct_push;
   rsp_type           direct_word;
   logic [31:0]       seq_next;

   assign newest    = (wp_ff == '0) ? AW'(DEPTH - 1) : wp_ff - 1'b1;
   assign first_sum = SW'(wp_ff) + SW'(DEPTH) - SW'(fill_ff);
   assign first     = (first_sum >= SW'(DEPTH)) ? AW'(first_sum - SW'(DEPTH)) : AW'(first_sum);
   assign fill7     = 7'(fill_ff);
   assign n7        = (fill7 < cmd_word.limit) ? fill7 : cmd_word.limit;
   assign snap_n    = FW'(n7);
   assign rd_ptr_next = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
   assign seq_next  = seq_ff + 32'd1;

   // A RAM read is started only when its result is sure to find room in the
   // result queue when the registered read data arrives.
   assign occupancy = {1'b0, rsp_count} + {{RSP_COUNT_W{1'b0}}, pend_ff};
   assign room      = occupancy < (RSP_COUNT_W + 1)'(RSP_QUEUE_DEPTH);

   assign ram_wslot.source       = cmd_word.source;
   assign ram_wslot.code         = cmd_word.code;
   assign ram_wslot.time_ms      = cmd_word.event_time;
   assign ram_wslot.sequence_num = seq_next;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      seq_in       = seq_ff;
      rd_ptr_in    = rd_ptr_ff;
      remain_in    = remain_ff;
      pend_in      = 1'b0;
      pend_last_in = pend_last_ff;
      cmd_pop      = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = rd_ptr_ff;
      direct_push  = 1'b0;
      direct_word  = '{status: STATUS_NONE, out_source: '0, out_code: '0,
                       out_time: '0, out_sequence: '0, last_of_run: 1'b1};
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty && !pend_ff && room) begin
               cmd_pop = 1'b1;
               case (cmd_word.op)
                  OP_RECORD: begin
                     ram_we      = 1'b1;
                     seq_in      = seq_next;
                     wp_in       = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
                     if (fill_ff != FW'(DEPTH)) begin
                        fill_in = fill_ff + 1'b1;
                     end
                     direct_push = 1'b1;
                     direct_word = '{status: STATUS_GOOD, out_source: cmd_word.source,
                                     out_code: cmd_word.code,
                                     out_time: cmd_word.event_time,
                                     out_sequence: seq_next, last_of_run: 1'b1};
                  end
                  OP_READ_LAST: begin
                     if (fill_ff == '0) begin
                        direct_push = 1'b1;
                     end else begin
                        ram_re       = 1'b1;
                        ram_raddr    = newest;
                        pend_in      = 1'b1;
                        pend_last_in = 1'b1;
                     end
                  end
                  OP_SNAPSHOT: begin
                     if (cmd_word.limit_zero || fill_ff == '0) begin
                        direct_push = 1'b1;
                     end else begin
                        rd_ptr_in = first;
                        remain_in = snap_n;
                        state_in  = ST_SNAP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SNAP: begin
            if (room) begin
               ram_re       = 1'b1;
               ram_raddr    = rd_ptr_ff;
               pend_in      = 1'b1;
               pend_last_in = (remain_ff == FW'(1));
               rd_ptr_in    = rd_ptr_next;
               remain_in    = remain_ff - 1'b1;
               if (remain_ff == FW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         wp_ff     <= '0;
         fill_ff   <= '0;
         seq_ff    <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         wp_ff     <= wp_in;
         fill_ff   <= fill_in;
         seq_ff    <= seq_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      remain_ff    <= remain_in;
      pend_last_ff <= pend_last_in;
   end

   otetb_ram #(
      .WIDTH(SLOT_W),
      .DEPTH(DEPTH)
   ) u_slots (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(wp_ff),
      .wr_data(SLOT_W'(ram_wslot)),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rbits)
   );

   assign ram_rslot = slot_type'(ram_rbits);

   // Read data and direct results never fall in the same cycle.
   always_comb begin
      if (pend_ff) begin
         rsp_push = 1'b1;
         rsp_word = '{status: STATUS_GOOD, out_source: ram_rslot.source,
                      out_code: ram_rslot.code, out_time: ram_rslot.time_ms,
                      out_sequence: ram_rslot.sequence_num,
                      last_of_run: pend_last_ff};
      end else begin
         rsp_push = direct_push;
         rsp_word = direct_word;
      end
   end

endmodule

// ===== hw/rtl/overwriting_event_trace_buffer_core.sv =====
// Top level of the overwriting event trace buffer.
// Depends on otetb_pkg, otetb_front, otetb_back, otetb_fifo and otetb_ram.
//
// Usage: request words enter through push/full like a queue write; a word is
// taken at a clock edge with push high and full low. Result words leave like
// a queue read: the oldest result sits on rsp_word while empty is low and is
// taken at an edge with pop high. A record word stores its event in a ring of
// DEPTH slots, overwriting the oldest once full, and returns the event with
// its new sequence number. A read-last word returns the newest event, and a
// snapshot word streams up to limit events, oldest first, marking the last.
// Words of an unused kind are taken and give no result.
//
// Flow: a record's result is pushed into the result queue in the same cycle
// that the back end pops the record. A read-last takes a RAM read, then a
// cycle for the registered read data, in which its result is pushed. A
// snapshot first sets its read pointer, then reads its events oldest first,
// one event per cycle while the result queue has room, set by the single
// read port of the slot RAM. A two-word command queue lets new words be
// taken while the back works.
//
// Reset clears the write pointer, fill count, sequence counter, state and both
// queues; slot contents and the snapshot read pointer are not cleared. When the
// receiver stalls, the result queue fills, the back end pauses, then the command queue fills and full rises.
module overwriting_event_trace_buffer_core #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  otetb_pkg::req_type req_word,
   output logic               empty,
   input  logic               pop,
   output otetb_pkg::rsp_type rsp_word
);
   import otetb_pkg::*;

   localparam int RSP_W = $bits(rsp_type);

   logic                   cmd_empty, cmd_pop;
   cmd_type                cmd_word;
   logic [RSP_COUNT_W-1:0] rsp_count;
   logic                   rsp_push;
   rsp_type                rsp_new;
   logic [RSP_W-1:0]       rsp_bits;
   logic                   rsp_full;

   otetb_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_word (req_word),
      .cmd_pop  (cmd_pop),
      .cmd_empty(cmd_empty),
      .cmd_word (cmd_word)
   );

   otetb_back #(
      .DEPTH(DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_empty(cmd_empty),
      .cmd_word (cmd_word),
      .cmd_pop  (cmd_pop),
      .rsp_count(rsp_count),
      .rsp_push (rsp_push),
      .rsp_word (rsp_new)
   );

   // The back end only pushes when it has reserved room, so rsp_full is
   // never high at a push.
   otetb_fifo #(
      .WIDTH(RSP_W),
      .DEPTH(RSP_QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rsp_push && !rsp_full),
      .push_data(RSP_W'(rsp_new)),
      .full     (rsp_full),
      .pop      (pop),
      .pop_data (rsp_bits),
      .empty    (empty),
      .count    (rsp_count)
   );

   assign rsp_word = rsp_type'(rsp_bits);

endmodule

// ===== test/tb.sv =====
// Testbench for the overwriting event trace buffer core.
// Depends on otetb_pkg for the word types and kind codes, and on the core itself.
// It drives request words, mirrors the ring in a local model and checks every result word.
module tb;
   import otetb_pkg::*;

   localparam int RING_DEPTH = 16;

   // The request kind that the block takes and then ignores.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // The run stops with a failure if it is still going after this many cycles.
   localparam int CYCLE_LIMIT = 600000;

   // Cycles to let pass once the last result word has arrived.
   localparam int DRAIN_CYCLES = 20;

   // Cycles that the receiver holds pop low in the back-pressure test.
   localparam int LONG_HOLD_CYCLES = 300;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    push     = 1'b0;
   logic    pop      = 1'b0;
   req_type req_word = '0;
   logic    full;
   logic    empty;
   rsp_type rsp_word;

   // Local mirror of the ring, its pointers and the sequence counter.
   slot_type    mirror_slot [RING_DEPTH];
   logic [3:0]  mirror_wr_ptr = '0;
   int          mirror_fill   = 0;
   logic [31:0] mirror_seq    = '0;

   // Result words that the block still owes, oldest first.
   rsp_type trace_words_due [$];

   int error_count     = 0;
   int cycle_count     = 0;
   int req_idle_max    = 6;
   int rsp_idle_max    = 6;
   int rsp_hold_cycles = 0;

   overwriting_event_trace_buffer_core #(
      .DEPTH (RING_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_word (req_word),
      .empty    (empty),
      .pop      (pop),
      .rsp_word (rsp_word)
   );

   always #5 clock = ~clock;

   // The watchdog. A correct run finishes far below the limit, so reaching it
   // means the block has stopped moving words.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: done, errors");
         $finish;
      end
   end

   // Every failure goes through here: one line, one count.
   task automatic report_mismatch(input string msg);
      $display("tb: %s", msg);
      error_count++;
   endtask

   // Builds the result word for an event, or for an empty answer.
   function automatic rsp_type event_word(input logic st, input slot_type s, input logic last);
      rsp_type r;
      r.status       = st;
      r.out_source   = s.source;
      r.out_code     = s.code;
      r.out_time     = s.time_ms;
      r.out_sequence = s.sequence_num;
      r.last_of_run  = last;
      return r;
   endfunction

   // Advances the mirror by one accepted request word and queues the result
   // words that the word must cause. The back end handles words in order, so
   // the mirror can be stepped at the moment of acceptance.
   task automatic model_trace_word(input req_type w);
      slot_type   s;
      int         n;
      logic [3:0] first;
      s = '0;
      case (w.kind)
         KIND_RECORD: begin
            mirror_seq     = mirror_seq + 32'd1;
            s.source       = w.source;
            s.code         = w.code;
            s.time_ms      = w.event_time;
            s.sequence_num = mirror_seq;
            mirror_slot[mirror_wr_ptr] = s;
            mirror_wr_ptr  = mirror_wr_ptr + 4'd1;
            if (mirror_fill < RING_DEPTH) begin
               mirror_fill++;
            end
            trace_words_due.push_back(event_word(STATUS_GOOD, s, 1'b1));
         end
         KIND_READ_LAST: begin
            if (mirror_fill == 0) begin
               trace_words_due.push_back(event_word(STATUS_NONE, s, 1'b1));
            end else begin
               trace_words_due.push_back(
                  event_word(STATUS_GOOD, mirror_slot[mirror_wr_ptr - 4'd1], 1'b1));
            end
         end
         KIND_SNAPSHOT: begin
            if (w.limit == 7'd0 || mirror_fill == 0) begin
               trace_words_due.push_back(event_word(STATUS_NONE, s, 1'b1));
            end else begin
               // The oldest stored event sits fill slots behind the write pointer.
               n     = (mirror_fill < int'(w.limit)) ? mirror_fill : int'(w.limit);
               first = mirror_wr_ptr - 4'(mirror_fill);
               for (int i = 0; i < n; i++) begin
                  trace_words_due.push_back(
                     event_word(STATUS_GOOD, mirror_slot[first + 4'(i)], i == n - 1));
               end
            end
         end
         default: begin
            // The unused kind is swallowed and produces no result word.
         end
      endcase
   endtask

   // Compares one accepted result word, field by field, with the oldest one due.
   task automatic check_trace_word(input rsp_type got);
      rsp_type want;
      if (trace_words_due.size() == 0) begin
         report_mismatch($sformatf("unexpected result word %h", got));
      end else begin
         want = trace_words_due.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status: got %0h, want %0h",
                                      got.status, want.status));
         if (got.out_source !== want.out_source)
            report_mismatch($sformatf("out_source: got %0h, want %0h",
                                      got.out_source, want.out_source));
         if (got.out_code !== want.out_code)
            report_mismatch($sformatf("out_code: got %0h, want %0h",
                                      got.out_code, want.out_code));
         if (got.out_time !== want.out_time)
            report_mismatch($sformatf("out_time: got %0h, want %0h",
                                      got.out_time, want.out_time));
         if (got.out_sequence !== want.out_sequence)
            report_mismatch($sformatf("out_sequence: got %0h, want %0h",
                                      got.out_sequence, want.out_sequence));
         if (got.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("last_of_run: got %0h, want %0h",
                                      got.last_of_run, want.last_of_run));
      end
   endtask

   // Offers one request word after a random gap and returns once the block
   // has taken it. Inputs only change at the falling edge; acceptance is
   // judged from the values seen at the rising edge. When the gap is zero,
   // push simply stays high, so it never gets two updates in one step.
   task automatic send_trace_word(input req_type w);
      int gap;
      gap = $urandom_range(0, req_idle_max);
      @(negedge clock);
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push     <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (full !== 1'b0);
      model_trace_word(w);
   endtask

   function automatic req_type make_word(input logic [1:0] kind, input logic [7:0] src,
                                         input logic [7:0] cd, input logic [31:0] ts,
                                         input logic [6:0] lim);
      req_type w;
      w.kind       = kind;
      w.source     = src;
      w.code       = cd;
      w.event_time = ts;
      w.limit      = lim;
      return w;
   endfunction

   // A word with random content of the given kind. Most snapshot limits stay
   // within the ring depth; a few are zero or reach past it up to 64.
   function automatic req_type random_word(input logic [1:0] kind);
      logic [6:0] lim;
      case ($urandom_range(0, 9))
         0:       lim = 7'd0;
         1:       lim = ($urandom_range(0, 1) != 0) ? 7'd64 : 7'($urandom_range(17, 64));
         default: lim = 7'($urandom_range(1, RING_DEPTH));
      endcase
      return make_word(kind, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       $urandom, lim);
   endfunction

   // The receiver. It waits a random number of cycles before each word, or a
   // long stretch when a test asks for one, and then pops the next word.
   initial begin : result_drain
      int gap;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles != 0) begin
            gap             = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            gap = $urandom_range(0, rsp_idle_max);
         end
         if (gap != 0) begin
            pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty !== 1'b0);
         check_trace_word(rsp_word);
      end
   end

   // Read-last and snapshot on a buffer that has never been written must
   // both answer with the empty status.
   task automatic test_empty_buffer();
      send_trace_word(random_word(KIND_READ_LAST));
      send_trace_word(make_word(KIND_SNAPSHOT, 8'hA5, 8'h5A, 32'h1234_5678, 7'd5));
   endtask

   // Records with all-zero and all-one fields, then a read of the newest one.
   task automatic test_record_extremes();
      send_trace_word(make_word(KIND_RECORD, 8'h00, 8'h00, 32'h0000_0000, 7'd0));
      send_trace_word(make_word(KIND_RECORD, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 7'h7F));
      send_trace_word(make_word(KIND_READ_LAST, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 7'h7F));
   endtask

   // A zero limit on a filled buffer gives the empty status; a limit of one
   // gives just the oldest event; a limit of 64 is clamped by the fill count.
   task automatic test_snapshot_limits();
      send_trace_word(make_word(KIND_SNAPSHOT, 8'h00, 8'h00, 32'h0, 7'd0));
      send_trace_word(make_word(KIND_SNAPSHOT, 8'h00, 8'h00, 32'h0, 7'd1));
      send_trace_word(make_word(KIND_SNAPSHOT, 8'h00, 8'h00, 32'h0, 7'd64));
   endtask

   // Enough records to wrap the ring and overwrite the oldest events, then a
   // read of the newest and a full snapshot that starts mid-ring.
   task automatic test_ring_wrap();
      repeat (15) send_trace_word(random_word(KIND_RECORD));
      send_trace_word(random_word(KIND_READ_LAST));
      send_trace_word(make_word(KIND_SNAPSHOT, 8'h00, 8'h00, 32'h0, 7'd64));
   endtask

   // A word of the unused kind must leave no trace; the read after it shows
   // the state unchanged.
   task automatic test_unused_kind();
      send_trace_word(random_word(KIND_UNUSED));
      send_trace_word(random_word(KIND_READ_LAST));
   endtask

   // The receiver stops for a long stretch while the sender keeps offering
   // records back to back. The result queue, then the command queue fill and
   // full must hold the sender off without losing a word.
   task automatic test_receiver_hold();
      req_idle_max    = 0;
      rsp_hold_cycles = LONG_HOLD_CYCLES;
      repeat (40) send_trace_word(random_word(KIND_RECORD));
      send_trace_word(make_word(KIND_SNAPSHOT, 8'h00, 8'h00, 32'h0, 7'd64));
      req_idle_max = 6;
   endtask

   // Random traffic in stretches of 30 words. Records dominate so the ring
   // stays mostly full and snapshots start at changing places; each stretch
   // turns idling on or off for each side on its own.
   task automatic test_random_traffic();
      int pick;
      for (int i = 0; i < 260; i++) begin
         if (i % 30 == 0) begin
            req_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
            rsp_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
         end
         pick = $urandom_range(0, 19);
         if (pick < 10)
            send_trace_word(random_word(KIND_RECORD));
         else if (pick < 14)
            send_trace_word(random_word(KIND_READ_LAST));
         else if (pick < 19)
            send_trace_word(random_word(KIND_SNAPSHOT));
         else
            send_trace_word(random_word(KIND_UNUSED));
      end
      req_idle_max = 6;
      rsp_idle_max = 6;
   endtask

   initial begin : stimulus
      foreach (mirror_slot[i]) mirror_slot[i] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_buffer();
      test_record_extremes();
      test_snapshot_limits();
      test_ring_wrap();
      test_unused_kind();
      test_receiver_hold();
      test_random_traffic();

      @(negedge clock);
      push <= 1'b0;

      // Wait for every owed word, then a little longer so that a stray extra
      // word would still be caught by the receiver.
      while (trace_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/otetb_pkg.sv
hw/rtl/otetb_ram.sv
hw/rtl/otetb_fifo.sv
hw/rtl/otetb_front.sv
hw/rtl/otetb_back.sv
hw/rtl/overwriting_event_trace_buffer_core.sv
test/tb.sv
